/* hw/rtl/epoch_seconds_to_calendar_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the epoch-to-calendar core
// Clocked, reset-gated property checks used by the core RTL file.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH

// property checked at every rising edge outside reset
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked at every rising edge outside reset
`define ESC_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

/* hw/rtl/esc_pkg.sv */
// ---------------------------------------------------------------------------
// esc_pkg
// Constants and helpers for the epoch-to-calendar core.
// ---------------------------------------------------------------------------
package esc_pkg;

  localparam int DSR_W        = 18;      // widest divisor (days per era)
  localparam int OUT_TDATA_W  = 72;      // 65 result bits padded to bytes
  localparam int YEAR_W       = 39;

  localparam logic [DSR_W-1:0] SECS_PER_DAY = 18'd86400;
  localparam logic [DSR_W-1:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [DSR_W-1:0] DAYS_4Y      = 18'd1460;
  localparam logic [DSR_W-1:0] DAYS_100Y    = 18'd36524;
  localparam logic [DSR_W-1:0] DAYS_ERA_M1  = 18'd146096;
  localparam logic [DSR_W-1:0] DAYS_YEAR    = 18'd365;
  localparam logic [DSR_W-1:0] YEARS_100    = 18'd100;
  localparam logic [DSR_W-1:0] MONTH_DIV    = 18'd153;
  localparam logic [DSR_W-1:0] SIXTY        = 18'd60;

  // 1970-01-01 counted from 0000-03-01
  localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;

  // first day (0-based) of a March-based month: (153*mp+2)/5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] v;
    begin
      case (mp)
        4'd0:    v = 9'd0;
        4'd1:    v = 9'd31;
        4'd2:    v = 9'd61;
        4'd3:    v = 9'd92;
        4'd4:    v = 9'd122;
        4'd5:    v = 9'd153;
        4'd6:    v = 9'd184;
        4'd7:    v = 9'd214;
        4'd8:    v = 9'd245;
        4'd9:    v = 9'd275;
        4'd10:   v = 9'd306;
        4'd11:   v = 9'd337;
        default: v = 9'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* hw/rtl/epoch_seconds_to_calendar_core.sv */
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Signed epoch seconds plus zone offset to Gregorian date and time of day.
// ---------------------------------------------------------------------------
// Input beat on s_axis: epoch seconds and zone hour/minute offsets.
// Output beat on m_axis: year, month, day, hour, minute, second; tuser
// carries the zone-out-of-range flag. One output beat per input beat.
// All divisions run on one shared bit-serial divider, one quotient bit per
// cycle; the divider sets the latency, which is dominated by the day split
// (SECONDS_WIDTH bits) and the era split (SECONDS_WIDTH-16 bits) of the ten
// divider steps. One beat is in work at a time; s_axis_tready is high only
// while idle, so a new beat is accepted only once the last one's result has
// been loaded into the output register.
// A finished result sits in the output register; the next input beat is
// accepted while it waits. If the receiver stalls, the core finishes the
// next beat and then holds until the output register frees.
// Reset (rst, synchronous) drops m_axis_tvalid and returns to idle.
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_core_macros.svh"

module epoch_seconds_to_calendar_core
  import esc_pkg::*;
#(
  parameter int SECONDS_WIDTH = 63
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // epoch_seconds, zone_hour_offset[5], zone_minute_offset[7], zero pad
  input  logic [((SECONDS_WIDTH+12+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // year_out[39], month_out[4], day_out[5], hour_out[5], minute_out[6],
  // second_out[6], zero pad
  output logic [OUT_TDATA_W-1:0]                    m_axis_tdata,
  // zone_invalid
  output logic                                      m_axis_tuser
);

  localparam int W  = SECONDS_WIDTH;
  localparam int AW = W + 1;
  localparam int CW = $clog2(W+1);
  localparam logic [CW-1:0] CNT_DAY = CW'(W);
  localparam logic [CW-1:0] CNT_ERA = CW'(W-16);
  localparam logic [CW-1:0] CNT_18  = CW'(18);
  localparam logic [CW-1:0] CNT_17  = CW'(17);
  localparam logic [CW-1:0] CNT_11  = CW'(11);
  localparam logic [CW-1:0] CNT_9   = CW'(9);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_GO, S_WAIT, S_POST, S_YEAR1, S_YEAR2
  } state_t;

  typedef enum logic [3:0] {
    ST_DAY, ST_ERA, ST_A, ST_B, ST_C, ST_YOE, ST_C100, ST_MP, ST_MIN, ST_HR
  } step_t;

  state_t state;
  step_t  step;
  logic   out_load;

  // input fields
  logic signed [W-1:0]  in_secs;
  logic signed [4:0]    in_zh;
  logic signed [6:0]    in_zm;
  logic signed [10:0]   off_min;
  logic signed [16:0]   off_sec;
  logic signed [AW-1:0] total;
  logic                 bad_in;

  assign in_secs = s_axis_tdata[W-1:0];
  assign in_zh   = s_axis_tdata[W+4:W];
  assign in_zm   = s_axis_tdata[W+11:W+5];
  assign off_min = 11'(in_zh * 11'sd60) + 11'(in_zm);
  assign off_sec = 17'(off_min * 17'sd60);
  assign total   = AW'(in_secs) + AW'(off_sec);
  assign bad_in  = (in_zh < -5'sd12) || (in_zh > 5'sd14) ||
                   (in_zm < -7'sd59) || (in_zm > 7'sd59);

  // working registers
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] era;
  logic                 neg;
  logic                 zone_bad;
  logic [16:0]          rem_day;
  logic [17:0]          doe;
  logic [17:0]          tyr;
  logic [8:0]           yoe;
  logic [8:0]           doy;
  logic [3:0]           month;
  logic [4:0]           day;
  logic [4:0]           hour;
  logic [5:0]           minute;
  logic [5:0]           second;
  logic [10:0]          tmin;

  // divider interface
  logic                 div_start;
  logic [W-1:0]         div_dvd;
  logic [DSR_W-1:0]     div_dsr;
  logic [CW-1:0]        div_cnt;
  logic                 div_busy;
  logic                 div_done;
  logic [W-1:0]         div_q;
  logic [DSR_W-1:0]     div_r;

  esc_div #(.DW(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .count     (div_cnt),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  logic [AW-1:0]   mag;
  logic [AW-1:0]   qx;
  logic [AW-1:0]   q_floor;
  logic            r_nz;
  logic [10:0]     mp_num;
  logic [17:0]     doy_wide;
  logic [8:0]      day_wide;
  logic [AW-1:0]   year_full;

  assign mag     = acc[W] ? AW'(-acc) : AW'(acc);
  assign qx      = {1'b0, div_q};
  assign r_nz    = (div_r != '0);
  // floor quotient of a signed dividend from the magnitude result
  assign q_floor = neg ? (r_nz ? ~qx : AW'(-qx)) : qx;
  assign mp_num  = 11'(doy) * 11'd5 + 11'd2;
  assign doy_wide = doe - 18'(yoe * 18'd365) - 18'(yoe[8:2]) + div_q[17:0];
  assign day_wide = doy - month_start(div_q[3:0]) + 9'd1;
  assign year_full = acc + AW'(yoe) + AW'((month <= 4'd2) ? 1 : 0);

  assign out_load = (state == S_YEAR2) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= ST_DAY;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            acc      <= total;
            zone_bad <= bad_in;
            step     <= ST_DAY;
            state    <= S_GO;
          end
        end
        S_PREP: begin
          acc   <= acc + AW'(DAYS_TO_EPOCH);
          state <= S_GO;
        end
        S_GO: begin
          neg       <= acc[W];
          div_start <= 1'b1;
          state     <= S_WAIT;
          case (step)
            ST_DAY: begin
              div_dvd <= mag[W-1:0];
              div_dsr <= SECS_PER_DAY;
              div_cnt <= CNT_DAY;
            end
            ST_ERA: begin
              div_dvd <= {mag[W-17:0], 16'd0};
              div_dsr <= DAYS_PER_ERA;
              div_cnt <= CNT_ERA;
            end
            ST_A: begin
              div_dvd <= {doe, {(W-18){1'b0}}};
              div_dsr <= DAYS_4Y;
              div_cnt <= CNT_18;
            end
            ST_B: begin
              div_dvd <= {doe, {(W-18){1'b0}}};
              div_dsr <= DAYS_100Y;
              div_cnt <= CNT_18;
            end
            ST_C: begin
              div_dvd <= {doe, {(W-18){1'b0}}};
              div_dsr <= DAYS_ERA_M1;
              div_cnt <= CNT_18;
            end
            ST_YOE: begin
              div_dvd <= {tyr, {(W-18){1'b0}}};
              div_dsr <= DAYS_YEAR;
              div_cnt <= CNT_18;
            end
            ST_C100: begin
              div_dvd <= {yoe, {(W-9){1'b0}}};
              div_dsr <= YEARS_100;
              div_cnt <= CNT_9;
            end
            ST_MP: begin
              div_dvd <= {mp_num, {(W-11){1'b0}}};
              div_dsr <= MONTH_DIV;
              div_cnt <= CNT_11;
            end
            ST_MIN: begin
              div_dvd <= {rem_day, {(W-17){1'b0}}};
              div_dsr <= SIXTY;
              div_cnt <= CNT_17;
            end
            ST_HR: begin
              div_dvd <= {tmin, {(W-11){1'b0}}};
              div_dsr <= SIXTY;
              div_cnt <= CNT_11;
            end
            default: begin
              div_dvd <= '0;
              div_dsr <= SIXTY;
              div_cnt <= CNT_9;
            end
          endcase
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          case (step)
            ST_DAY: begin
              acc     <= q_floor;
              rem_day <= (neg && r_nz) ? 17'(SECS_PER_DAY - div_r) : div_r[16:0];
              step    <= ST_ERA;
              state   <= S_PREP;
            end
            ST_ERA: begin
              era   <= q_floor;
              doe   <= (neg && r_nz) ? (DAYS_PER_ERA - div_r) : div_r;
              tyr   <= (neg && r_nz) ? (DAYS_PER_ERA - div_r) : div_r;
              step  <= ST_A;
              state <= S_GO;
            end
            ST_A: begin
              tyr   <= tyr - div_q[17:0];
              step  <= ST_B;
              state <= S_GO;
            end
            ST_B: begin
              tyr   <= tyr + div_q[17:0];
              step  <= ST_C;
              state <= S_GO;
            end
            ST_C: begin
              tyr   <= tyr - div_q[17:0];
              step  <= ST_YOE;
              state <= S_GO;
            end
            ST_YOE: begin
              yoe   <= div_q[8:0];
              step  <= ST_C100;
              state <= S_GO;
            end
            ST_C100: begin
              doy   <= doy_wide[8:0];
              step  <= ST_MP;
              state <= S_GO;
            end
            ST_MP: begin
              day   <= day_wide[4:0];
              month <= (div_q[3:0] < 4'd10) ? div_q[3:0] + 4'd3 : div_q[3:0] - 4'd9;
              step  <= ST_MIN;
              state <= S_GO;
            end
            ST_MIN: begin
              second <= div_r[5:0];
              tmin   <= div_q[10:0];
              step   <= ST_HR;
              state  <= S_GO;
            end
            ST_HR: begin
              minute <= div_r[5:0];
              hour   <= div_q[4:0];
              step   <= ST_DAY;
              state  <= S_YEAR1;
            end
            default: begin
              step  <= ST_DAY;
              state <= S_IDLE;
            end
          endcase
        end
        S_YEAR1: begin
          // era * 400 by shift-and-add
          acc   <= (era <<< 8) + (era <<< 7) + (era <<< 4);
          state <= S_YEAR2;
        end
        S_YEAR2: begin
          if (out_load) begin
            m_axis_tdata  <= {7'd0, second, minute, hour, day, month,
                              year_full[YEAR_W-1:0]};
            m_axis_tuser  <= zone_bad;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  `ESC_ASSERT_IMP(a_idle_div_quiet, s_axis_tready, !div_busy, "divider busy while idle")
  `ESC_ASSERT_IMP(a_month_range, m_axis_tvalid,
    (m_axis_tdata[42:39] >= 4'd1) && (m_axis_tdata[42:39] <= 4'd12), "month out of range")
  `ESC_ASSERT_IMP(a_time_range, m_axis_tvalid,
    (m_axis_tdata[52:48] < 5'd24) && (m_axis_tdata[58:53] < 6'd60) &&
    (m_axis_tdata[64:59] < 6'd60), "time of day out of range")
  `ESC_ASSERT(a_done_after_busy, div_done |-> $past(div_busy), "divider done without work")

endmodule

/* hw/rtl/esc_div.sv */
// ---------------------------------------------------------------------------
// esc_div
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
// ---------------------------------------------------------------------------
module esc_div
  import esc_pkg::*;
#(
  parameter int DW = 63
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,  // top count bits consumed first
  input  logic [DSR_W-1:0]           divisor,
  input  logic [$clog2(DW+1)-1:0]    count,
  output logic                       busy,
  output logic                       done,
  output logic [DW-1:0]              quotient,
  output logic [DSR_W-1:0]           remainder
);

  localparam int CW = $clog2(DW+1);

  logic [DW-1:0]    dvd;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic [DSR_W:0]   trial;
  logic             ge;

  assign trial = {rem, dvd[DW-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= count;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
        dvd <= {dvd[DW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

/* bench/tb_epoch_seconds_to_calendar_core.sv */
// ---------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core
// Self-checking bench: drives epoch seconds and zone offsets, predicts the
// calendar date and time of day, and compares every output beat in order.
// ---------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_core;
  import esc_pkg::*;

  localparam int SW = 63;
  localparam int IN_W = ((SW + 12 + 7) / 8) * 8;
  localparam int WATCHDOG = 20000;

  // ordered to match {m_axis_tdata[64:0], m_axis_tuser}
  typedef struct packed {
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic              zbad;
  } cal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  logic [IN_W-1:0] pending_beats[$];
  cal_t expected_dates[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int drv_wait = 0;
  int rcv_wait = 0;

  epoch_seconds_to_calendar_core #(.SECONDS_WIDTH(SW)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic cal_t to_calendar(logic [IN_W-1:0] beat);
    longint secs, zh, zm, ofs, days, rem, carry, z, era, doe, yoe, doy, mp, mon, yr;
    cal_t r;
    secs = longint'(signed'(beat[SW-1:0]));
    zh = longint'(signed'(beat[SW+4:SW]));
    zm = longint'(signed'(beat[SW+11:SW+5]));
    ofs = (zh * 60 + zm) * 60;
    days = fdiv(secs, 86400);
    rem = secs - days * 86400 + ofs;
    carry = fdiv(rem, 86400);
    days += carry;
    rem -= carry * 86400;
    z = days + 719468;
    era = fdiv(z, 146097);
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    r.year = yr[YEAR_W-1:0];
    r.month = mon[3:0];
    r.day = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.hour = 5'(rem / 3600);
    r.minute = 6'((rem / 60) % 60);
    r.second = 6'(rem % 60);
    r.zbad = (zh < -12 || zh > 14 || zm < -59 || zm > 59);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_beat(logic [SW-1:0] s, logic [4:0] h,
                                                logic [6:0] m);
    logic [IN_W-1:0] b;
    b = '0;
    b[SW-1:0] = s;
    b[SW+4:SW] = h;
    b[SW+11:SW+5] = m;
    return b;
  endfunction

  function automatic logic [SW-1:0] rand_secs();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return w[SW-1:0];                                   // full range
      1: return SW'(signed'(w[40:0]));                       // within about 35 thousand years
      2: return SW'(signed'(w[33:0]));                       // a few centuries
      default: return SW'(longint'($urandom_range(0, 4000)) * 86400
                          - 173000000000 + $urandom_range(0, 3) - 2); // near 04:26:40 UTC on many days
    endcase
  endfunction

  initial begin
    logic [SW-1:0] s;
    logic [4:0] h;
    logic [6:0] m;
    // extremes, epoch, leap days, zone range edges
    pending_beats.push_back(pack_beat('0, 5'd0, 7'd0));
    pending_beats.push_back(pack_beat({1'b0, {(SW-1){1'b1}}}, 5'd14, 7'd59));
    pending_beats.push_back(pack_beat({1'b1, {(SW-1){1'b0}}}, -5'sd12, -7'sd59));
    pending_beats.push_back(pack_beat({1'b0, {(SW-1){1'b1}}}, 5'd15, 7'd63));
    pending_beats.push_back(pack_beat({1'b1, {(SW-1){1'b0}}}, -5'sd16, -7'sd64));
    pending_beats.push_back(pack_beat(-63'sd1, 5'd0, 7'd0));
    pending_beats.push_back(pack_beat(-63'sd86400, 5'd0, 7'd0));
    pending_beats.push_back(pack_beat(-63'sd86401, 5'd0, 7'd0));
    pending_beats.push_back(pack_beat(63'd951782400, 5'd0, 7'd0));   // 2000-02-29
    pending_beats.push_back(pack_beat(63'd4107542400, 5'd0, 7'd0));  // 2100-03-01
    pending_beats.push_back(pack_beat(-63'sd62167219200, 5'd0, 7'd0)); // 0000-01-01
    pending_beats.push_back(pack_beat(-63'sd62162035200, 5'd0, 7'd0)); // 0000-02-29 area
    pending_beats.push_back(pack_beat(-63'sd62167219201, 5'd0, 7'd0)); // year -1
    pending_beats.push_back(pack_beat(63'd86399, 5'd14, 7'd59));
    pending_beats.push_back(pack_beat(63'd0, -5'sd12, -7'sd59));
    pending_beats.push_back(pack_beat(63'd0, 5'd0, 7'd60));
    pending_beats.push_back(pack_beat(63'd0, 5'd0, -7'sd60));
    pending_beats.push_back(pack_beat(63'd0, -5'sd13, 7'd0));
    pending_beats.push_back(pack_beat(63'd1709164800, 5'd0, 7'd0));  // 2024-02-29
    for (int i = 0; i < 1100; i++) begin
      s = rand_secs();
      if ($urandom_range(0, 4) == 0) begin
        h = 5'($urandom);
        m = 7'($urandom);
      end else begin
        h = 5'($urandom_range(0, 26) - 12);
        m = 7'($urandom_range(0, 118) - 59);
      end
      pending_beats.push_back(pack_beat(s, h, m));
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // driver
  always @(negedge clk) begin
    int rcv_draw;
    if (!rst) begin
      if (in_fire) begin
        drv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        s_axis_tvalid <= 1'b0;
        if (pending_beats.size() == 0) stim_done <= 1'b1;
      end else if (!s_axis_tvalid) begin
        if (drv_wait > 0) drv_wait <= drv_wait - 1;
        else if (pending_beats.size() > 0) begin
          s_axis_tdata <= pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
        end
      end
      if (out_fire) begin
        rcv_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        m_axis_tready <= (rcv_draw == 0);
        rcv_wait <= (rcv_draw > 0) ? rcv_draw - 1 : 0;
      end else if (rcv_wait > 0) begin
        m_axis_tready <= 1'b0;
        rcv_wait <= rcv_wait - 1;
      end else m_axis_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    cal_t got, want;
    if (!rst) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready)
        expected_dates.push_back(to_calendar(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[YEAR_W+25:0], m_axis_tuser};
        if (expected_dates.size() == 0) begin
          $error("output beat with no expected result");
          errors++;
        end else begin
          want = expected_dates.pop_front();
          if (got.year !== want.year) begin
            $error("year_out: expected %0d got %0d", $signed(want.year), $signed(got.year));
            errors++;
          end
          if (got.month !== want.month) begin
            $error("month_out: expected %0d got %0d", want.month, got.month);
            errors++;
          end
          if (got.day !== want.day) begin
            $error("day_out: expected %0d got %0d", want.day, got.day);
            errors++;
          end
          if (got.hour !== want.hour) begin
            $error("hour_out: expected %0d got %0d", want.hour, got.hour);
            errors++;
          end
          if (got.minute !== want.minute) begin
            $error("minute_out: expected %0d got %0d", want.minute, got.minute);
            errors++;
          end
          if (got.second !== want.second) begin
            $error("second_out: expected %0d got %0d", want.second, got.second);
            errors++;
          end
          if (got.zbad !== want.zbad) begin
            $error("zone_invalid: expected %0d got %0d", want.zbad, got.zbad);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    fork
      begin
        wait (stim_done && expected_dates.size() == 0);
        repeat (300) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        errors++;
      end
    join_any
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/esc_pkg.sv
hw/rtl/esc_div.sv
hw/rtl/epoch_seconds_to_calendar_core.sv
bench/tb_epoch_seconds_to_calendar_core.sv
